### hw/rtl/fetx_pkg.sv
// Shared types, constants and helpers of the fragmenting escaped frame transmitter.
package fetx_pkg;

  // Chunk size and frame limit of one message.
  localparam logic [7:0]  MTU        = 8'd72;
  localparam int          MaxFrames  = 255;
  localparam logic [15:0] MAX_LEN    = 16'(int'(MTU) * MaxFrames);

  // Frame byte constants.
  localparam logic [7:0] DELIM      = 8'h7E;
  localparam logic [7:0] ESC        = 8'h7D;
  localparam logic [7:0] XON        = 8'h11;
  localparam logic [7:0] XOFF       = 8'h13;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] FRAME_TYPE = 8'h10;
  localparam logic [7:0] LEN_HI     = 8'h00;
  localparam logic [7:0] HDR_EXTRA  = 8'd15;
  localparam logic [7:0] FRAG_BASE  = 8'h30;
  localparam logic [7:0] BANG       = 8'h21;
  localparam logic [7:0] SUM_BASE   = 8'hFF;

  // Configuration register indexes.
  localparam logic [2:0] REG_ADDR64   = 3'd0;
  localparam logic [2:0] REG_ADDR16   = 3'd1;
  localparam logic [2:0] REG_FRAME_ID = 3'd2;
  localparam logic [2:0] REG_OPTIONS  = 3'd3;
  localparam logic [2:0] REG_RADIUS   = 3'd4;

  // Byte positions within one frame.
  localparam logic [4:0] POS_DELIM     = 5'd0;
  localparam logic [4:0] POS_LEN_HI    = 5'd1;
  localparam logic [4:0] POS_LEN_LO    = 5'd2;
  localparam logic [4:0] POS_TYPE      = 5'd3;
  localparam logic [4:0] POS_ID        = 5'd4;
  localparam logic [4:0] POS_A64_FIRST = 5'd5;
  localparam logic [4:0] POS_A64_LAST  = 5'd12;
  localparam logic [4:0] POS_A16_HI    = 5'd13;
  localparam logic [4:0] POS_A16_LO    = 5'd14;
  localparam logic [4:0] POS_OPT       = 5'd15;
  localparam logic [4:0] POS_RAD       = 5'd16;
  localparam logic [4:0] POS_FRAG      = 5'd17;
  localparam logic [4:0] POS_DATA      = 5'd18;
  localparam logic [4:0] POS_BANG      = 5'd19;
  localparam logic [4:0] POS_CSUM      = 5'd20;

  // What follows the data byte of a command.
  typedef enum logic [1:0] {
    END_NONE,
    END_CHECK,
    END_FINAL
  } end_e;

  // One classified message byte, handed from front to back.
  typedef struct packed {
    logic       refused;
    logic       hdr;
    end_e       end_kind;
    logic [7:0] len_byte;
    logic [7:0] frag;
    logic [7:0] data;
  } cmd_t;

  // Header fields taken from the configuration registers.
  typedef struct packed {
    logic [63:0] addr64;
    logic [15:0] addr16;
    logic [7:0]  frame_id;
    logic [7:0]  options;
    logic [7:0]  radius;
  } hdr_cfg_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       message_end;
    logic       status;
    logic       run_last;
  } res_t;

  function automatic logic needs_esc(input logic [7:0] b);
    needs_esc = (b == ESC) || (b == DELIM) || (b == XON) || (b == XOFF);
  endfunction

endpackage

### hw/rtl/fragmenting_escaped_frame_tx.sv
// Fragmenting escaped transmit-request framer: top level with configuration registers.
// With the queue empty, an accepted item passes the queue and then the output register
//   before its first result can be taken.
// Throughput: one result per cycle from the back end while out_stall_i is low; an item
//   yields one result (plain data byte) up to a full escaped frame (header, data, '!', checksum).
// A four-entry queue lets the front take items while the back emits frame bytes.
// Reset clears message state, queue and output valid; registers return to their reset values.
module fragmenting_escaped_frame_tx (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        message_end_o,
  output logic        status_o,
  output logic        run_last_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  fetx_pkg::hdr_cfg_t cfg_q, cfg_d;
  fetx_pkg::cmd_t     push_cmd;
  fetx_pkg::cmd_t     head_cmd;
  fetx_pkg::res_t     res;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;

  // Register writes: an index beyond the list is ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fetx_pkg::REG_ADDR64:   cfg_d.addr64   = cfg_data_i;
        fetx_pkg::REG_ADDR16:   cfg_d.addr16   = cfg_data_i[15:0];
        fetx_pkg::REG_FRAME_ID: cfg_d.frame_id = cfg_data_i[7:0];
        fetx_pkg::REG_OPTIONS:  cfg_d.options  = cfg_data_i[7:0];
        fetx_pkg::REG_RADIUS:   cfg_d.radius   = cfg_data_i[7:0];
        default:                cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.addr64   <= 64'd0;
      cfg_q.addr16   <= 16'hFFFE;
      cfg_q.frame_id <= 8'h01;
      cfg_q.options  <= 8'h00;
      cfg_q.radius   <= 8'h00;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify each message byte and push one command, unless it opens a zero-length message.
  fetx_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .message_length_i (message_length_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  // Queue: decouple the byte-per-item front from the multi-byte back.
  fetx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  // Back: expand each command into escaped frame bytes, or one status result if it is refused.
  fetx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign out_byte_o    = res.out_byte;
  assign frame_end_o   = res.frame_end;
  assign message_end_o = res.message_end;
  assign status_o      = res.status;
  assign run_last_o    = res.run_last;

endmodule

### hw/rtl/fetx_front.sv
// Front end: accepts message bytes, tracks message and chunk position, classifies each byte.
module fetx_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic [15:0]        message_length_i,
  input  logic               q_full_i,
  output logic               push_o,
  output fetx_pkg::cmd_t     cmd_o
);

  logic [15:0] bytes_left_q, bytes_left_d;
  logic [7:0]  chunk_idx_q, chunk_idx_d;
  logic [7:0]  chunk_pos_q, chunk_pos_d;
  logic        refusing_q, refusing_d;

  logic        accept;
  logic        is_new;
  logic [15:0] bl;
  logic [15:0] bl_m1;
  logic [7:0]  cp;
  logic [7:0]  ci;
  logic [7:0]  cp_n;
  logic        refuse;
  logic        fin;
  logic [7:0]  chunk;
  fetx_pkg::end_e end_kind;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    is_new = (bytes_left_q == 16'd0);
    bl     = is_new ? message_length_i : bytes_left_q;
    cp     = is_new ? 8'd0 : chunk_pos_q;
    ci     = is_new ? 8'd0 : chunk_idx_q;
    refuse = is_new ? (message_length_i > fetx_pkg::MAX_LEN) : refusing_q;
    bl_m1  = bl - 16'd1;
    cp_n   = cp + 8'd1;
    fin    = (bl <= {8'd0, fetx_pkg::MTU});
    chunk  = (bl < {8'd0, fetx_pkg::MTU}) ? bl[7:0] : fetx_pkg::MTU;

    if (bl_m1 == 16'd0) begin
      end_kind = fetx_pkg::END_FINAL;
    end else if (cp_n >= fetx_pkg::MTU) begin
      end_kind = fetx_pkg::END_CHECK;
    end else begin
      end_kind = fetx_pkg::END_NONE;
    end

    cmd_o.refused  = refuse;
    cmd_o.hdr      = (cp == 8'd0);
    cmd_o.end_kind = end_kind;
    cmd_o.len_byte = chunk + fetx_pkg::HDR_EXTRA + {7'd0, fin};
    cmd_o.frag     = ci + fetx_pkg::FRAG_BASE;
    cmd_o.data     = data_byte_i;

    // Drop a first byte that carries zero length: no message opens.
    push_o = accept && !(is_new && (message_length_i == 16'd0));

    bytes_left_d = bytes_left_q;
    chunk_idx_d  = chunk_idx_q;
    chunk_pos_d  = chunk_pos_q;
    refusing_d   = refusing_q;
    if (push_o) begin
      bytes_left_d = bl_m1;
      if (refuse) begin
        refusing_d  = (bl_m1 != 16'd0);
        chunk_idx_d = 8'd0;
        chunk_pos_d = 8'd0;
      end else begin
        refusing_d = 1'b0;
        case (end_kind)
          fetx_pkg::END_FINAL: begin
            chunk_idx_d = 8'd0;
            chunk_pos_d = 8'd0;
          end
          fetx_pkg::END_CHECK: begin
            chunk_idx_d = ci + 8'd1;
            chunk_pos_d = 8'd0;
          end
          default: begin
            chunk_idx_d = ci;
            chunk_pos_d = cp_n;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      chunk_idx_q  <= '0;
      chunk_pos_q  <= '0;
      refusing_q   <= 1'b0;
    end else begin
      bytes_left_q <= bytes_left_d;
      chunk_idx_q  <= chunk_idx_d;
      chunk_pos_q  <= chunk_pos_d;
      refusing_q   <= refusing_d;
    end
  end

endmodule

### hw/rtl/fetx_queue.sv
// Four-entry command queue between front and back.
module fetx_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fetx_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fetx_pkg::cmd_t head_o
);

  fetx_pkg::cmd_t mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;

  assign full_o  = (count_q == 3'd4);
  assign empty_o = (count_q == 3'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + {1'b0, push_i};
    rd_ptr_d = rd_ptr_q + {1'b0, pop_i};
    count_d  = count_q + {2'd0, push_i} - {2'd0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### hw/rtl/fetx_back.sv
// Back end: walks the frame bytes of each command, escapes them and keeps the checksum.
module fetx_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  fetx_pkg::cmd_t     head_i,
  output logic               pop_o,
  input  fetx_pkg::hdr_cfg_t cfg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fetx_pkg::res_t     res_o
);

  logic [4:0] pos_q, pos_d;
  logic       active_q, active_d;
  logic       esc_q, esc_d;
  logic [7:0] sum_q, sum_d;
  logic       out_valid_q, out_valid_d;
  fetx_pkg::res_t res_q, res_d;

  logic [4:0] cur_pos;
  logic [4:0] next_pos;
  logic [2:0] a64_sel;
  logic [7:0] raw;
  logic       esc_needed;
  logic       final_piece;
  logic       cmd_done;
  logic       emit;

  always_comb begin
    cur_pos = active_q ? pos_q
            : (head_i.hdr ? fetx_pkg::POS_DELIM : fetx_pkg::POS_DATA);
    a64_sel = 3'(fetx_pkg::POS_A64_LAST - cur_pos);

    if (cur_pos inside {[fetx_pkg::POS_A64_FIRST:fetx_pkg::POS_A64_LAST]}) begin
      raw = cfg_i.addr64[{a64_sel, 3'b000} +: 8];
    end else begin
      case (cur_pos)
        fetx_pkg::POS_DELIM:  raw = fetx_pkg::DELIM;
        fetx_pkg::POS_LEN_HI: raw = fetx_pkg::LEN_HI;
        fetx_pkg::POS_LEN_LO: raw = head_i.len_byte;
        fetx_pkg::POS_TYPE:   raw = fetx_pkg::FRAME_TYPE;
        fetx_pkg::POS_ID:     raw = cfg_i.frame_id;
        fetx_pkg::POS_A16_HI: raw = cfg_i.addr16[15:8];
        fetx_pkg::POS_A16_LO: raw = cfg_i.addr16[7:0];
        fetx_pkg::POS_OPT:    raw = cfg_i.options;
        fetx_pkg::POS_RAD:    raw = cfg_i.radius;
        fetx_pkg::POS_FRAG:   raw = head_i.frag;
        fetx_pkg::POS_DATA:   raw = head_i.data;
        fetx_pkg::POS_BANG:   raw = fetx_pkg::BANG;
        fetx_pkg::POS_CSUM:   raw = fetx_pkg::SUM_BASE - sum_q;
        default:              raw = '0;
      endcase
    end

    esc_needed  = !head_i.refused && (cur_pos != fetx_pkg::POS_DELIM)
                  && fetx_pkg::needs_esc(raw);
    final_piece = !esc_needed || esc_q;

    // Pick the position after this byte; data routes by the command's end kind.
    if (cur_pos == fetx_pkg::POS_DATA) begin
      case (head_i.end_kind)
        fetx_pkg::END_FINAL: next_pos = fetx_pkg::POS_BANG;
        fetx_pkg::END_CHECK: next_pos = fetx_pkg::POS_CSUM;
        default:             next_pos = fetx_pkg::POS_DATA;
      endcase
    end else begin
      next_pos = cur_pos + 5'd1;
    end

    cmd_done = head_i.refused
               || (final_piece
                   && (((cur_pos == fetx_pkg::POS_DATA)
                        && (head_i.end_kind == fetx_pkg::END_NONE))
                       || (cur_pos == fetx_pkg::POS_CSUM)));

    emit  = !q_empty_i && (!out_valid_q || !out_stall_i);
    pop_o = emit && cmd_done;

    res_d.status      = head_i.refused;
    res_d.run_last    = cmd_done;
    res_d.frame_end   = !head_i.refused && final_piece && (cur_pos == fetx_pkg::POS_CSUM);
    res_d.message_end = res_d.frame_end && (head_i.end_kind == fetx_pkg::END_FINAL);
    if (head_i.refused) begin
      res_d.out_byte = '0;
    end else if (esc_needed && !esc_q) begin
      res_d.out_byte = fetx_pkg::ESC;
    end else if (esc_needed) begin
      res_d.out_byte = raw ^ fetx_pkg::ESC_XOR;
    end else begin
      res_d.out_byte = raw;
    end

    pos_d       = pos_q;
    active_d    = active_q;
    esc_d       = esc_q;
    sum_d       = sum_q;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    if (emit) begin
      out_valid_d = 1'b1;
      if (cmd_done) begin
        active_d = 1'b0;
        esc_d    = 1'b0;
      end else if (final_piece) begin
        active_d = 1'b1;
        esc_d    = 1'b0;
        pos_d    = next_pos;
      end else begin
        active_d = 1'b1;
        esc_d    = 1'b1;
        pos_d    = cur_pos;
      end
      if (!head_i.refused) begin
        if (cur_pos == fetx_pkg::POS_DELIM) begin
          sum_d = '0;
        end else if (final_piece && (cur_pos >= fetx_pkg::POS_TYPE)
                     && (cur_pos <= fetx_pkg::POS_BANG)) begin
          sum_d = sum_q + raw;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= fetx_pkg::POS_DELIM;
      active_q    <= 1'b0;
      esc_q       <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      active_q    <= active_d;
      esc_q       <= esc_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
